>>> rtl/core/mbi_pkg.sv
`default_nettype none

package mbi_pkg;

    // field widths
    localparam int COORD_BITS = 16;
    localparam int COUNT_BITS = 24;
    localparam int LABEL_W    = 8;
    localparam int Q_W        = 16;
    localparam int TOTAL_W    = 24;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // datapath widths
    localparam int EDGE_W  = COORD_BITS + 3;
    localparam int OVL_W   = COORD_BITS + 1;
    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int INTER_W = 2 * OVL_W;
    localparam int AREA_W  = 2 * COORD_BITS + 3;
    localparam int SUM_W   = COUNT_BITS + Q_W;
    localparam int DIV_W   = (AREA_W > COUNT_BITS) ? AREA_W : COUNT_BITS;
    localparam int QCNT_W  = $clog2(Q_W);
    localparam int WIDE_W  = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

    // stream widths
    localparam int IN_DATA_W  = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((Q_W + TOTAL_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LABEL_W;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_NONE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_DUMMY = 1'd1;
    localparam logic [LABEL_W-1:0] SKIP_NONE_RST  = 8'd0;
    localparam logic [LABEL_W-1:0] SKIP_DUMMY_RST = 8'd255;

    // one grid cell
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pred_x;
        logic signed [COORD_BITS-1:0] pred_y;
        logic        [COORD_BITS-1:0] pred_w;
        logic        [COORD_BITS-1:0] pred_h;
        logic signed [COORD_BITS-1:0] truth_x;
        logic signed [COORD_BITS-1:0] truth_y;
        logic        [COORD_BITS-1:0] truth_w;
        logic        [COORD_BITS-1:0] truth_h;
        logic        [LABEL_W-1:0]    cell_label;
        logic                         batch_end;
    } cell_t;

    // controller to datapath
    typedef struct packed {
        logic load_cell;
        logic calc_edge;
        logic calc_mul;
        logic calc_area;
        logic calc_union;
        logic div_start_iou;
        logic div_start_mean;
        logic div_step;
        logic accumulate;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic counted;
        logic batch_end;
        logic count_zero;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/mean_box_iou_accumulator.sv
// mean_box_iou_accumulator: mean IoU of center-form box pairs over a batch
//
// input stream: one grid cell per word, predicted and truth boxes in tdata,
// the cell label in tuser, tlast on the last cell of a batch. cells whose
// label matches either skip register are not counted.
// output stream: one word per batch, taken on the tlast cell: mean IoU in
// Q1.15 and the number of counted cells (0 and 0 if nothing was counted).
// config port: cfg_we/cfg_index/cfg_data, write only while the block is idle.
//
// occupancy: a counted cell occupies the block through edges, three
// multiplies, area, union, 16 steps of the shared restoring divider and
// the accumulate, a skipped cell only through the edge step. no new cell
// is taken before the last one is done. on a tlast cell the same divider
// then computes sum / count unless nothing was counted.
// the result sits in an output register: the block keeps accepting cells
// while it waits; only the next batch result waits for the slot to free up.
// reset clears sum, count and handshake state and loads the skip labels
// with 0 and 255.
`default_nettype none

module mean_box_iou_accumulator import mbi_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // cell input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pred_x, pred_y, pred_w, pred_h, truth_x, truth_y, truth_w, truth_h
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // cell_label
    input  wire logic [LABEL_W-1:0]    s_tuser,
    // batch_end
    input  wire logic                  s_tlast,
    // batch result
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // mean_iou, object_total
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    cell_t              cell_in;
    cmd_t               cmd;
    status_t            status;
    logic [Q_W-1:0]     mean_iou;
    logic [TOTAL_W-1:0] object_total;

    // unpack the input word
    always_comb
    begin
        cell_in.pred_x     = s_tdata[0*COORD_BITS +: COORD_BITS];
        cell_in.pred_y     = s_tdata[1*COORD_BITS +: COORD_BITS];
        cell_in.pred_w     = s_tdata[2*COORD_BITS +: COORD_BITS];
        cell_in.pred_h     = s_tdata[3*COORD_BITS +: COORD_BITS];
        cell_in.truth_x    = s_tdata[4*COORD_BITS +: COORD_BITS];
        cell_in.truth_y    = s_tdata[5*COORD_BITS +: COORD_BITS];
        cell_in.truth_w    = s_tdata[6*COORD_BITS +: COORD_BITS];
        cell_in.truth_h    = s_tdata[7*COORD_BITS +: COORD_BITS];
        cell_in.cell_label = s_tuser;
        cell_in.batch_end  = s_tlast;
    end

    mbi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbi_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_in      (cell_in),
        .cmd          (cmd),
        .status       (status),
        .mean_iou     (mean_iou),
        .object_total (object_total)
    );

    // pack the result word
    assign m_tdata = OUT_DATA_W'({object_total, mean_iou});

endmodule

`default_nettype wire

>>> rtl/core/mbi_divider.sv
`default_nettype none

// restoring divider, one quotient bit per step
// needs hi < divisor so the quotient fits in Q_W bits
module mbi_divider import mbi_pkg::*; (
    input  wire logic             clk,
    input  wire logic             start,
    input  wire logic             step,
    input  wire logic [DIV_W-1:0] hi,
    input  wire logic [Q_W-1:0]   lo,
    input  wire logic [DIV_W-1:0] divisor,
    output logic      [Q_W-1:0]   quotient
);

    logic [DIV_W-1:0] rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [DIV_W-1:0] den_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // shift in next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, low_reg[Q_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= hi;
            low_reg <= lo;
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[Q_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/mbi_datapath.sv
`default_nettype none

module mbi_datapath import mbi_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire cell_t                 cell_in,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output logic      [Q_W-1:0]        mean_iou,
    output logic      [TOTAL_W-1:0]    object_total
);

    logic [LABEL_W-1:0]    skip_none_reg;
    logic [LABEL_W-1:0]    skip_dummy_reg;
    cell_t                 cell_reg;
    logic [OVL_W-1:0]      ow_reg;
    logic [OVL_W-1:0]      oh_reg;
    logic [INTER_W-1:0]    inter_reg;
    logic [PROD_W-1:0]     pa_reg;
    logic [PROD_W-1:0]     ta_reg;
    logic [AREA_W-1:0]     area_reg;
    logic [AREA_W-1:0]     union_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [Q_W-1:0]        mean_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [DIV_W-1:0]      div_hi;
    logic [Q_W-1:0]        div_lo;
    logic [DIV_W-1:0]      div_den;
    logic [Q_W-1:0]        quotient;
    logic [Q_W-1:0]        iou;
    logic [WIDE_W-1:0]     count_wide;
    logic [TOTAL_W-1:0]    total_sat;
    logic                  union_zero;
    logic                  div_start;

    // overlap of two intervals at doubled coordinates
    function automatic logic [OVL_W-1:0] overlap2(
        input logic signed [COORD_BITS-1:0] c0,
        input logic        [COORD_BITS-1:0] s0,
        input logic signed [COORD_BITS-1:0] c1,
        input logic        [COORD_BITS-1:0] s1
    );
        logic signed [EDGE_W-1:0] b0;
        logic signed [EDGE_W-1:0] e0;
        logic signed [EDGE_W-1:0] b1;
        logic signed [EDGE_W-1:0] e1;
        logic signed [EDGE_W-1:0] b;
        logic signed [EDGE_W-1:0] e;
        logic signed [EDGE_W-1:0] d;
        b0 = (EDGE_W'(c0) <<< 1) - $signed(EDGE_W'(s0));
        e0 = (EDGE_W'(c0) <<< 1) + $signed(EDGE_W'(s0));
        b1 = (EDGE_W'(c1) <<< 1) - $signed(EDGE_W'(s1));
        e1 = (EDGE_W'(c1) <<< 1) + $signed(EDGE_W'(s1));
        b  = (b0 > b1) ? b0 : b1;
        e  = (e0 < e1) ? e0 : e1;
        d  = e - b;
        return (b < e) ? d[OVL_W-1:0] : '0;
    endfunction

    // skip labels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_none_reg  <= SKIP_NONE_RST;
            skip_dummy_reg <= SKIP_DUMMY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SKIP_NONE:  skip_none_reg  <= cfg_data;
                REG_SKIP_DUMMY: skip_dummy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // cell capture and iou pipeline steps
    always_ff @(posedge clk)
    begin
        if (cmd.load_cell)
            cell_reg <= cell_in;
        if (cmd.calc_edge)
        begin
            ow_reg <= overlap2(cell_reg.pred_x, cell_reg.pred_w,
                               cell_reg.truth_x, cell_reg.truth_w);
            oh_reg <= overlap2(cell_reg.pred_y, cell_reg.pred_h,
                               cell_reg.truth_y, cell_reg.truth_h);
        end
        if (cmd.calc_mul)
        begin
            inter_reg <= INTER_W'(ow_reg) * INTER_W'(oh_reg);
            pa_reg    <= PROD_W'(cell_reg.pred_w) * PROD_W'(cell_reg.pred_h);
            ta_reg    <= PROD_W'(cell_reg.truth_w) * PROD_W'(cell_reg.truth_h);
        end
        if (cmd.calc_area)
            area_reg <= (AREA_W'(pa_reg) << 2) + (AREA_W'(ta_reg) << 2);
        if (cmd.calc_union)
            union_reg <= area_reg - AREA_W'(inter_reg);
    end

    assign union_zero = union_reg == '0;

    // divider operands: inter*2^15 / union, or sum / count
    always_comb
    begin
        if (cmd.div_start_mean)
        begin
            div_hi  = DIV_W'(sum_reg[SUM_W-1:Q_W]);
            div_lo  = sum_reg[Q_W-1:0];
            div_den = DIV_W'(count_reg);
        end
        else
        begin
            div_hi  = DIV_W'(inter_reg[INTER_W-1:1]);
            div_lo  = {inter_reg[0], {(Q_W-1){1'b0}}};
            div_den = DIV_W'(union_reg);
        end
    end

    assign div_start = cmd.div_start_iou | cmd.div_start_mean;

    mbi_divider u_div (
        .clk      (clk),
        .start    (div_start),
        .step     (cmd.div_step),
        .hi       (div_hi),
        .lo       (div_lo),
        .divisor  (div_den),
        .quotient (quotient)
    );

    assign iou = union_zero ? '0 : quotient;

    // saturate count to the output field
    always_comb
    begin
        count_wide = WIDE_W'(count_reg);
        if (count_wide > WIDE_W'(TOTAL_MAX))
            total_sat = TOTAL_MAX;
        else
            total_sat = count_wide[TOTAL_W-1:0];
    end

    // running sum and object count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.accumulate)
        begin
            sum_reg   <= sum_reg + SUM_W'(iou);
            count_reg <= count_reg + 1'b1;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mean_reg  <= (count_reg == '0) ? '0 : quotient;
            total_reg <= total_sat;
        end
    end

    always_comb
    begin
        status.counted    = (cell_reg.cell_label != skip_none_reg) &&
                            (cell_reg.cell_label != skip_dummy_reg) &&
                            (count_reg != {COUNT_BITS{1'b1}});
        status.batch_end  = cell_reg.batch_end;
        status.count_zero = count_reg == '0;
    end

    assign mean_iou     = mean_reg;
    assign object_total = total_reg;

endmodule

`default_nettype wire

>>> rtl/core/mbi_ctrl.sv
`default_nettype none

module mbi_ctrl import mbi_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EDGE   = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_AREA   = 4'd3;
    localparam logic [3:0] S_UNION  = 4'd4;
    localparam logic [3:0] S_ISTART = 4'd5;
    localparam logic [3:0] S_IDIV   = 4'd6;
    localparam logic [3:0] S_ACC    = 4'd7;
    localparam logic [3:0] S_MSTART = 4'd8;
    localparam logic [3:0] S_MDIV   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    localparam logic [QCNT_W-1:0] STEP_LAST = QCNT_W'(Q_W - 1);

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [QCNT_W-1:0] step_reg;
    logic [QCNT_W-1:0] step_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              accept;
    logic              out_free;

    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_cell = accept;
                if (accept)
                    state_next = S_EDGE;
            end
            S_EDGE:
            begin
                cmd.calc_edge = 1'b1;
                if (status.counted)
                    state_next = S_MUL;
                else if (!status.batch_end)
                    state_next = S_IDLE;
                else if (status.count_zero)
                    state_next = S_OUT;
                else
                    state_next = S_MSTART;
            end
            S_MUL:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = S_AREA;
            end
            S_AREA:
            begin
                cmd.calc_area = 1'b1;
                state_next    = S_UNION;
            end
            S_UNION:
            begin
                cmd.calc_union = 1'b1;
                state_next     = S_ISTART;
            end
            S_ISTART:
            begin
                cmd.div_start_iou = 1'b1;
                step_next         = '0;
                state_next        = S_IDIV;
            end
            S_IDIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = status.batch_end ? S_MSTART : S_IDLE;
            end
            S_MSTART:
            begin
                cmd.div_start_mean = 1'b1;
                step_next          = '0;
                state_next         = S_MDIV;
            end
            S_MDIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to be free
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/mbi_checker.sv
`default_nettype none

module mbi_checker import mbi_pkg::*; (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    // result word holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result word changed while stalled");

    // mean never exceeds one in Q1.15
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[Q_W-1:0] <= 16'd32768)
    else $error("mean iou above one");

    // empty batch reports zero mean
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[Q_W +: TOTAL_W] == '0) |-> m_tdata[Q_W-1:0] == '0)
    else $error("nonzero mean with no objects");

    // a cell is never taken in back-to-back cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while previous cell in work");

endmodule

bind mean_box_iou_accumulator mbi_checker u_mbi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
